@@ rtl/core/winding_ray_accumulator_defines.svh @@
// assertion macros shared by the winding ray accumulator checker
`ifndef WINDING_RAY_ACCUMULATOR_DEFINES_SVH
`define WINDING_RAY_ACCUMULATOR_DEFINES_SVH

// checked only while out of reset
`define WRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define WRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/wra_pkg.sv @@
// shared widths, register codes and types of the winding ray accumulator
`timescale 1ns / 1ps

package wra_pkg;

  localparam int unsigned CoordW          = 63;
  localparam int unsigned DiffW           = 64;
  localparam int unsigned HalfW           = 32;
  localparam int unsigned ProdW           = 128;
  localparam int unsigned MultW           = 16;
  localparam int unsigned DeltaW          = MultW + 1;
  localparam int unsigned OutW            = 32;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned CfgDataW        = 63;
  localparam int unsigned WindingWidthDef = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOriginX = 1'b0,
    CfgOriginY = 1'b1
  } cfg_idx_e;

endpackage

@@ rtl/core/wra_if.sv @@
// edge and result channel interfaces of the winding ray accumulator
`timescale 1ns / 1ps

interface wra_edge_if;
  import wra_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] start_x;
  logic signed [CoordW-1:0] start_y;
  logic signed [CoordW-1:0] end_x;
  logic signed [CoordW-1:0] end_y;
  logic signed [MultW-1:0]  multiplicity;
  logic                     last_edge;

  modport source (
    output valid, start_x, start_y, end_x, end_y, multiplicity, last_edge,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, multiplicity, last_edge,
    output ready
  );
endinterface

interface wra_result_if;
  import wra_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] winding;
  logic                   saturated;

  modport source (
    output valid, winding, saturated,
    input  ready
  );
  modport sink (
    input  valid, winding, saturated,
    output ready
  );
endinterface

@@ rtl/core/winding_ray_accumulator.sv @@
// winding number of a query point over a stream of weighted edges, ray toward +x
// a last edge passes stages 1 to 5 and the result register before it shows on result_o
// throughput: one edge per cycle unless a last edge is held, with the five-stage pipeline
// and split multipliers on 32-bit halves; the accumulator adds one crossing per cycle
// reset: rst_ni is asynchronous and active low; it clears all valid bits, the running sum,
// the clip flag and both origin registers
`timescale 1ns / 1ps

module winding_ray_accumulator #(
  parameter int unsigned WINDING_WIDTH = wra_pkg::WindingWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wra_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wra_pkg::CfgDataW-1:0]  cfg_data_i,
  wra_edge_if.sink                      edge_i,
  wra_result_if.source                  result_o
);
  import wra_pkg::*;

  // partial products of one 64x64 signed multiply
  typedef struct packed {
    logic [DiffW-1:0]   hh;
    logic [HalfW*2:0]   hl;
    logic [HalfW*2:0]   lh;
    logic [DiffW-1:0]   ll;
  } pp_t;

  localparam int unsigned SumW  = ((WINDING_WIDTH > DeltaW) ? WINDING_WIDTH : DeltaW) + 1;
  localparam int unsigned WideW = (WINDING_WIDTH > OutW) ? WINDING_WIDTH : OutW;
  localparam logic signed [SumW-1:0] AccMax =
    {{(SumW-WINDING_WIDTH+1){1'b0}}, {(WINDING_WIDTH-1){1'b1}}};
  localparam logic signed [SumW-1:0] AccMin =
    {{(SumW-WINDING_WIDTH+1){1'b1}}, {(WINDING_WIDTH-1){1'b0}}};

  // split each operand into a signed high half and an unsigned low half
  function automatic pp_t part_prod(input logic signed [DiffW-1:0] a,
                                    input logic signed [DiffW-1:0] b);
    pp_t r;
    r.hh = $signed(a[DiffW-1:HalfW]) * $signed(b[DiffW-1:HalfW]);
    r.hl = $signed(a[DiffW-1:HalfW]) * $signed({1'b0, b[HalfW-1:0]});
    r.lh = $signed({1'b0, a[HalfW-1:0]}) * $signed(b[DiffW-1:HalfW]);
    r.ll = a[HalfW-1:0] * b[HalfW-1:0];
    return r;
  endfunction

  // weighted sum of the partial products, full 128-bit product
  function automatic logic signed [ProdW-1:0] pp_sum(input pp_t p);
    logic [ProdW-1:0] t_hh;
    logic [ProdW-1:0] t_hl;
    logic [ProdW-1:0] t_lh;
    logic [ProdW-1:0] t_ll;
    t_hh = {p.hh, {DiffW{1'b0}}};
    t_hl = {{(ProdW-HalfW*3-1){p.hl[HalfW*2]}}, p.hl, {HalfW{1'b0}}};
    t_lh = {{(ProdW-HalfW*3-1){p.lh[HalfW*2]}}, p.lh, {HalfW{1'b0}}};
    t_ll = {{(ProdW-DiffW){1'b0}}, p.ll};
    return $signed(t_hh + t_hl + t_lh + t_ll);
  endfunction

  // ---------------------------------------------------------------
  // configuration registers, which the user writes only while the block is idle (unenforced)
  // ---------------------------------------------------------------
  logic signed [CoordW-1:0] origin_x_q;
  logic signed [CoordW-1:0] origin_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgOriginX: origin_x_q <= $signed(cfg_data_i);
        CfgOriginY: origin_y_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // pipeline flow control: a stage takes new data when it is empty
  // or its content moves on; only a last edge can be held back by
  // a result that is still waiting
  // ---------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;
  logic out_valid_q;
  logic s5_last_q;

  assign s5_rdy = !s5_valid_q || !s5_last_q || !out_valid_q || result_o.ready;
  assign s4_rdy = !s4_valid_q || s5_rdy;
  assign s3_rdy = !s3_valid_q || s4_rdy;
  assign s2_rdy = !s2_valid_q || s3_rdy;
  assign s1_rdy = !s1_valid_q || s2_rdy;

  assign edge_i.ready = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_valid_q <= edge_i.valid;
      if (s2_rdy) s2_valid_q <= s1_valid_q;
      if (s3_rdy) s3_valid_q <= s2_valid_q;
      if (s4_rdy) s4_valid_q <= s3_valid_q;
      if (s5_rdy) s5_valid_q <= s4_valid_q;
    end
  end

  // ---------------------------------------------------------------
  // stage 1: input register
  // ---------------------------------------------------------------
  logic signed [CoordW-1:0] s1_sx_q, s1_sy_q, s1_ex_q, s1_ey_q;
  logic signed [MultW-1:0]  s1_mult_q;
  logic                     s1_last_q;

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_sx_q   <= edge_i.start_x;
      s1_sy_q   <= edge_i.start_y;
      s1_ex_q   <= edge_i.end_x;
      s1_ey_q   <= edge_i.end_y;
      s1_mult_q <= edge_i.multiplicity;
      s1_last_q <= edge_i.last_edge;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: order endpoints by y, span test and the four differences
  // both orders are subtracted in parallel, then picked by direction
  // ---------------------------------------------------------------
  logic                    s1_up;
  logic                    s2_span_d;
  logic signed [DiffW-1:0] s2_da_d, s2_db_d, s2_dc_d, s2_dd_d;

  always_comb begin
    s1_up = s1_sy_q < s1_ey_q;
    // half-open span [ymin, ymax); a horizontal edge never passes
    s2_span_d = s1_up ? (s1_sy_q <= origin_y_q) && (origin_y_q < s1_ey_q)
                      : (s1_ey_q <= origin_y_q) && (origin_y_q < s1_sy_q);
    // origin_x - xlo
    s2_da_d = s1_up ? DiffW'(origin_x_q) - DiffW'(s1_sx_q)
                    : DiffW'(origin_x_q) - DiffW'(s1_ex_q);
    // yhi - ylo
    s2_db_d = s1_up ? DiffW'(s1_ey_q) - DiffW'(s1_sy_q)
                    : DiffW'(s1_sy_q) - DiffW'(s1_ey_q);
    // xhi - xlo
    s2_dc_d = s1_up ? DiffW'(s1_ex_q) - DiffW'(s1_sx_q)
                    : DiffW'(s1_sx_q) - DiffW'(s1_ex_q);
    // origin_y - ylo
    s2_dd_d = s1_up ? DiffW'(origin_y_q) - DiffW'(s1_sy_q)
                    : DiffW'(origin_y_q) - DiffW'(s1_ey_q);
  end

  logic signed [DiffW-1:0] s2_da_q, s2_db_q, s2_dc_q, s2_dd_q;
  logic                    s2_span_q, s2_up_q, s2_last_q;
  logic signed [MultW-1:0] s2_mult_q;

  always_ff @(posedge clk_i) begin
    if (s2_rdy) begin
      s2_da_q   <= s2_da_d;
      s2_db_q   <= s2_db_d;
      s2_dc_q   <= s2_dc_d;
      s2_dd_q   <= s2_dd_d;
      s2_span_q <= s2_span_d;
      s2_up_q   <= s1_up;
      s2_mult_q <= s1_mult_q;
      s2_last_q <= s1_last_q;
    end
  end

  // ---------------------------------------------------------------
  // stage 3: partial products of both cross terms
  // ---------------------------------------------------------------
  pp_t                     s3_lhs_pp_q, s3_rhs_pp_q;
  logic                    s3_span_q, s3_up_q, s3_last_q;
  logic signed [MultW-1:0] s3_mult_q;

  always_ff @(posedge clk_i) begin
    if (s3_rdy) begin
      s3_lhs_pp_q <= part_prod(s2_da_q, s2_db_q);
      s3_rhs_pp_q <= part_prod(s2_dc_q, s2_dd_q);
      s3_span_q   <= s2_span_q;
      s3_up_q     <= s2_up_q;
      s3_mult_q   <= s2_mult_q;
      s3_last_q   <= s2_last_q;
    end
  end

  // ---------------------------------------------------------------
  // stage 4: full 128-bit products
  // ---------------------------------------------------------------
  logic signed [ProdW-1:0] s4_lhs_q, s4_rhs_q;
  logic                    s4_span_q, s4_up_q, s4_last_q;
  logic signed [MultW-1:0] s4_mult_q;

  always_ff @(posedge clk_i) begin
    if (s4_rdy) begin
      s4_lhs_q  <= pp_sum(s3_lhs_pp_q);
      s4_rhs_q  <= pp_sum(s3_rhs_pp_q);
      s4_span_q <= s3_span_q;
      s4_up_q   <= s3_up_q;
      s4_mult_q <= s3_mult_q;
      s4_last_q <= s3_last_q;
    end
  end

  // ---------------------------------------------------------------
  // stage 5: crossing test and signed weight; no crossing gives zero
  // ---------------------------------------------------------------
  logic                     s4_cross;
  logic signed [DeltaW-1:0] s4_mult_ext;
  logic signed [DeltaW-1:0] s5_delta_d;

  always_comb begin
    s4_cross    = s4_span_q && (s4_lhs_q < s4_rhs_q);
    s4_mult_ext = DeltaW'(s4_mult_q);
    if (!s4_cross) begin
      s5_delta_d = '0;
    end else if (s4_up_q) begin
      s5_delta_d = s4_mult_ext;
    end else begin
      s5_delta_d = -s4_mult_ext;
    end
  end

  logic signed [DeltaW-1:0] s5_delta_q;

  always_ff @(posedge clk_i) begin
    if (s5_rdy) begin
      s5_delta_q <= s5_delta_d;
      s5_last_q  <= s4_last_q;
    end
  end

  // ---------------------------------------------------------------
  // saturating accumulator and result register
  // ---------------------------------------------------------------
  logic signed [WINDING_WIDTH-1:0] acc_q, acc_d;
  logic                            clip_q, clip_d;
  logic signed [SumW-1:0]          acc_sum;
  logic signed [WINDING_WIDTH-1:0] acc_next;
  logic                            clip_next;
  logic                            acc_fire;
  logic                            out_valid_d;
  logic signed [OutW-1:0]          out_winding_q, out_winding_d;
  logic                            out_sat_q, out_sat_d;

  always_comb begin
    acc_sum   = SumW'(acc_q) + SumW'(s5_delta_q);
    clip_next = clip_q;
    priority if (acc_sum > AccMax) begin
      acc_next  = AccMax[WINDING_WIDTH-1:0];
      clip_next = 1'b1;
    end else if (acc_sum < AccMin) begin
      acc_next  = AccMin[WINDING_WIDTH-1:0];
      clip_next = 1'b1;
    end else begin
      acc_next  = acc_sum[WINDING_WIDTH-1:0];
    end

    acc_fire      = s5_valid_q && s5_rdy;
    acc_d         = acc_q;
    clip_d        = clip_q;
    out_valid_d   = out_valid_q && !result_o.ready;
    out_winding_d = out_winding_q;
    out_sat_d     = out_sat_q;
    if (acc_fire) begin
      if (s5_last_q) begin
        // last edge: emit the total with this edge counted, then clear
        acc_d         = '0;
        clip_d        = 1'b0;
        out_valid_d   = 1'b1;
        out_winding_d = OutW'(WideW'(acc_next));
        out_sat_d     = clip_next;
      end else begin
        acc_d  = acc_next;
        clip_d = clip_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_winding_q <= out_winding_d;
    out_sat_q     <= out_sat_d;
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.winding   = out_winding_q;
  assign result_o.saturated = out_sat_q;

endmodule

@@ rtl/core/wra_checker.sv @@
// port-level checker of the winding ray accumulator and its bind
`timescale 1ns / 1ps

`include "winding_ray_accumulator_defines.svh"

module wra_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_last_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [wra_pkg::OutW-1:0]     out_winding_i,
  input logic                         out_saturated_i
);
  import wra_pkg::*;

  localparam int unsigned PendW = 4;

  // last edges taken in whose result has not gone out yet
  logic [PendW-1:0] pending_q, pending_d;
  logic             last_in, res_out;

  always_comb begin
    last_in   = in_valid_i && in_ready_i && in_last_i;
    res_out   = out_valid_i && out_ready_i;
    pending_d = pending_q;
    if (last_in && !res_out) begin
      pending_d = pending_q + PendW'(1);
    end else if (!last_in && res_out) begin
      pending_d = pending_q - PendW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `WRA_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `WRA_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_winding_i) && $stable(out_saturated_i), "stalled result changed")
  `WRA_ASSERT(a_no_phantom, out_valid_i |-> pending_q != '0, "result without a last edge")
  `WRA_ASSERT(a_ready_idle, pending_q == '0 |-> in_ready_i, "input stalled with no result pending")
  `WRA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_i, "result valid in reset")

endmodule

bind winding_ray_accumulator wra_checker u_wra_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (edge_i.valid),
  .in_ready_i      (edge_i.ready),
  .in_last_i       (edge_i.last_edge),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .out_winding_i   (result_o.winding),
  .out_saturated_i (result_o.saturated)
);

@@ verif/wra_winding_checker.sv @@
// checker that predicts winding results from observed edge transfers and compares them
`timescale 1ns / 1ps

module wra_winding_checker #(
  parameter int unsigned WINDING_WIDTH = wra_pkg::WindingWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wra_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wra_pkg::CfgDataW-1:0] cfg_data_i,
  wra_edge_if                          edge_i,
  wra_result_if                        result_i,
  output int unsigned                  mismatch_cnt_o,
  output int unsigned                  pending_o
);
  import wra_pkg::*;

  // wide enough that one step past either end of a 64-bit sum cannot wrap
  localparam int unsigned SumW = 66;
  localparam logic signed [SumW-1:0] SumMax = (SumW'(1) <<< (WINDING_WIDTH - 1)) - 1;
  localparam logic signed [SumW-1:0] SumMin = -SumMax - 1;

  typedef struct packed {
    logic signed [OutW-1:0] winding;
    logic                   saturated;
  } winding_t;

  winding_t                 pending_windings[$];
  logic signed [CoordW-1:0] query_x_q   = '0;
  logic signed [CoordW-1:0] query_y_q   = '0;
  logic signed [SumW-1:0]   winding_acc = '0;
  logic                     clip_seen   = 1'b0;

  // signed weight the edge adds to the sum, zero when it misses the ray
  function automatic logic signed [DeltaW-1:0] crossing_weight(
    input logic signed [CoordW-1:0] sx,
    input logic signed [CoordW-1:0] sy,
    input logic signed [CoordW-1:0] ex,
    input logic signed [CoordW-1:0] ey,
    input logic signed [CoordW-1:0] ox,
    input logic signed [CoordW-1:0] oy,
    input logic signed [MultW-1:0]  mult
  );
    logic                     rising;
    logic signed [DiffW-1:0]  x_lo, y_lo, x_hi, y_hi, qx, qy;
    logic signed [ProdW-1:0]  cross_l, cross_r;
    logic signed [DeltaW-1:0] weight;
    rising = sy < ey;
    x_lo   = rising ? sx : ex;
    y_lo   = rising ? sy : ey;
    x_hi   = rising ? ex : sx;
    y_hi   = rising ? ey : sy;
    qx     = ox;
    qy     = oy;
    weight = mult;
    if (!rising) weight = -weight;
    // half-open span, so horizontal edges never qualify
    if (qy < y_lo || qy >= y_hi) return '0;
    cross_l = (qx - x_lo) * (y_hi - y_lo);
    cross_r = (x_hi - x_lo) * (qy - y_lo);
    if (cross_l < cross_r) return weight;
    return '0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    winding_t                 got, want;
    logic signed [DeltaW-1:0] delta;
    logic signed [SumW-1:0]   next_sum;
    if (!rst_ni) begin
      pending_windings.delete();
      query_x_q   = '0;
      query_y_q   = '0;
      winding_acc = '0;
      clip_seen   = 1'b0;
    end else begin
      // results first: a result never belongs to an edge of the same cycle
      if (result_i.valid === 1'b1 && result_i.ready === 1'b1) begin
        got.winding   = result_i.winding;
        got.saturated = result_i.saturated;
        if (pending_windings.size() == 0) begin
          $display("%0t: unexpected result, expected none, got winding %0d saturated %0b",
                   $time, got.winding, got.saturated);
          mismatch_cnt_o++;
        end else begin
          want = pending_windings.pop_front();
          if (got.winding !== want.winding) begin
            $display("%0t: winding mismatch, expected %0d, got %0d",
                     $time, want.winding, got.winding);
            mismatch_cnt_o++;
          end
          if (got.saturated !== want.saturated) begin
            $display("%0t: saturated mismatch, expected %0b, got %0b",
                     $time, want.saturated, got.saturated);
            mismatch_cnt_o++;
          end
        end
      end
      if (edge_i.valid === 1'b1 && edge_i.ready === 1'b1) begin
        delta = crossing_weight(edge_i.start_x, edge_i.start_y, edge_i.end_x, edge_i.end_y,
                                query_x_q, query_y_q, edge_i.multiplicity);
        next_sum = winding_acc + delta;
        if (next_sum > SumMax) begin
          winding_acc = SumMax;
          clip_seen   = 1'b1;
        end else if (next_sum < SumMin) begin
          winding_acc = SumMin;
          clip_seen   = 1'b1;
        end else begin
          winding_acc = next_sum;
        end
        if (edge_i.last_edge === 1'b1) begin
          want.winding   = winding_acc[OutW-1:0];
          want.saturated = clip_seen;
          pending_windings.insert(pending_windings.size(), want);
          winding_acc = '0;
          clip_seen   = 1'b0;
        end
      end
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          CfgOriginX: query_x_q = cfg_data_i;
          CfgOriginY: query_y_q = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = pending_windings.size();
  end

endmodule

@@ verif/testbench.sv @@
// top of the winding ray accumulator testbench: clock, reset, edge stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import wra_pkg::*;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned ResetCycles   = 10;
  // enough to empty the pipeline, for edges that make no result
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned PhaseEdges    = 615;
  // full-weight crossings in one long ray cast
  localparam int unsigned CastCrossings = 20;
  localparam int unsigned TimeLimitNs   = 8000000;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [MultW-1:0]  MultMax  = {1'b0, {(MultW-1){1'b1}}};
  localparam logic signed [MultW-1:0]  MultMin  = {1'b1, {(MultW-1){1'b0}}};

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CfgIdxW-1:0]       cfg_idx;
  logic [CfgDataW-1:0]      cfg_data;

  // idle percentages of the edge sender and the result receiver
  int unsigned              send_idle_pct = 28;
  int unsigned              recv_idle_pct = 87;
  int unsigned              edges_sent    = 0;
  int unsigned              mismatch_cnt;
  int unsigned              pending_cnt;

  // query point as last written, so shapes can be built around it
  logic signed [CoordW-1:0] query_x = '0;
  logic signed [CoordW-1:0] query_y = '0;

  wra_edge_if   edge_if ();
  wra_result_if result_if ();

  always #(ClkPeriod / 2) clk = ~clk;

  winding_ray_accumulator #(
    .WINDING_WIDTH (WindingWidthDef)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .edge_i     (edge_if),
    .result_o   (result_if)
  );

  wra_winding_checker #(
    .WINDING_WIDTH (WindingWidthDef)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .edge_i         (edge_if),
    .result_i       (result_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  // hard stop in case the block hangs
  initial begin
    #(TimeLimitNs);
    $display("FAIL");
    $finish;
  end

  // result receiver: random stalls, rate set by the current phase
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // mostly close to the query point, so crossings and near misses both happen
  function automatic logic signed [CoordW-1:0] pick_coord(
    input logic signed [CoordW-1:0] center
  );
    int off;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        off = $urandom_range(16);
        return center + CoordW'(off - 8);
      end
      4, 5: begin
        off = $urandom_range(32'h00FF_FFFF);
        return center + CoordW'(off - 32'sh0080_0000);
      end
      6, 7: return CoordW'({$urandom, $urandom});
      8: begin
        case ($urandom_range(3))
          0: return CoordMax;
          1: return CoordMin;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return center;
    endcase
  endfunction

  function automatic logic signed [MultW-1:0] pick_weight();
    case ($urandom_range(3))
      0: return MultW'($urandom_range(6)) - MultW'(3);
      1: begin
        case ($urandom_range(3))
          0: return MultMax;
          1: return MultMin;
          2: return MultW'(1);
          default: return '1;
        endcase
      end
      default: return MultW'($urandom);
    endcase
  endfunction

  // one edge transfer; entered and left at a falling edge, valid stays high on exit
  task automatic drive_edge(
    input logic signed [CoordW-1:0] sx,
    input logic signed [CoordW-1:0] sy,
    input logic signed [CoordW-1:0] ex,
    input logic signed [CoordW-1:0] ey,
    input logic signed [MultW-1:0]  mult,
    input bit                       last
  );
    while ($urandom_range(99) < send_idle_pct) begin
      edge_if.valid <= 1'b0;
      @(negedge clk);
    end
    edge_if.valid        <= 1'b1;
    edge_if.start_x      <= sx;
    edge_if.start_y      <= sy;
    edge_if.end_x        <= ex;
    edge_if.end_y        <= ey;
    edge_if.multiplicity <= mult;
    edge_if.last_edge    <= last;
    do @(posedge clk); while (edge_if.ready !== 1'b1);
    edge_if.valid <= edge_if.valid;
    edges_sent++;
    @(negedge clk);
  endtask

  // stop sending, wait for every winding result, then let the pipeline empty
  task automatic drain();
    edge_if.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // both origin registers on consecutive cycles, only while the block is idle
  task automatic set_origin(
    input logic signed [CoordW-1:0] ox,
    input logic signed [CoordW-1:0] oy
  );
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgOriginX;
    cfg_data <= ox;
    @(negedge clk);
    cfg_idx  <= CfgOriginY;
    cfg_data <= oy;
    @(negedge clk);
    cfg_we   <= 1'b0;
    query_x = ox;
    query_y = oy;
  endtask

  // closed polygon around the query point, last edge flagged
  task automatic send_polygon(input int unsigned corners);
    logic signed [CoordW-1:0] vx[8];
    logic signed [CoordW-1:0] vy[8];
    logic signed [MultW-1:0]  weight;
    bit                       mixed;
    int unsigned              nxt;
    weight = pick_weight();
    mixed  = ($urandom_range(3) == 0);
    for (int i = 0; i < corners; i++) begin
      vx[i] = pick_coord(query_x);
      vy[i] = pick_coord(query_y);
      // horizontal and vertical edges, and corners sitting on the ray line
      if (i > 0 && $urandom_range(5) == 0) vy[i] = vy[i-1];
      if (i > 0 && $urandom_range(5) == 0) vx[i] = vx[i-1];
      if ($urandom_range(7) == 0) vy[i] = query_y;
    end
    for (int i = 0; i < corners; i++) begin
      nxt = (i + 1) % corners;
      drive_edge(vx[i], vy[i], vx[nxt], vy[nxt], mixed ? pick_weight() : weight,
                 i == corners - 1);
    end
  endtask

  // unrelated edges, not a closed outline
  task automatic send_scatter(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      drive_edge(pick_coord(query_x), pick_coord(query_y), pick_coord(query_x),
                 pick_coord(query_y), pick_weight(), i == count - 1);
    end
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = edges_sent + PhaseEdges;
    while (edges_sent < target) begin
      if ($urandom_range(9) == 0) send_scatter($urandom_range(1, 5));
      else send_polygon($urandom_range(1, 8));
    end
    drain();
  endtask

  // one long ray cast of full-weight crossings in one direction
  task automatic send_long_cast(input bit rising);
    for (int unsigned n = 0; n < CastCrossings; n++) begin
      if (rising) drive_edge(query_x + 5, query_y - 1, query_x + 5, query_y + 1, MultMin, 1'b0);
      else drive_edge(query_x + 5, query_y + 1, query_x + 5, query_y - 1, MultMin, 1'b0);
    end
    // a unit step after the full-weight run
    drive_edge(query_x + 5, query_y - 1, query_x + 5, query_y + 1,
               rising ? MultW'(1) : MultW'(-1), 1'b0);
    // horizontal closing edge adds nothing
    drive_edge(query_x, query_y, query_x + 9, query_y, pick_weight(), 1'b1);
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = CfgOriginX;
    cfg_data             = '0;
    edge_if.valid        = 1'b0;
    edge_if.start_x      = '0;
    edge_if.start_y      = '0;
    edge_if.end_x        = '0;
    edge_if.end_y        = '0;
    edge_if.multiplicity = '0;
    edge_if.last_edge    = 1'b0;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed cases against the reset origin at zero
    drive_edge(1, 0, 5, 0, 7, 1'b0);                  // horizontal edge on the ray
    drive_edge(3, -2, 3, 2, 1, 1'b0);                 // upward crossing
    drive_edge(4, 2, 4, -2, MultMax, 1'b0);           // downward crossing
    drive_edge(-3, -2, -3, 2, 5, 1'b0);               // left of the query point
    drive_edge(2, 0, 2, 5, 3, 1'b0);                  // lower corner on the ray counts
    drive_edge(2, -5, 2, 0, 3, 1'b0);                 // upper corner on the ray does not
    drive_edge(-1, -1, 1, 1, 9, 1'b0);                // edge through the query point
    drive_edge(CoordMax, CoordMin, CoordMax, CoordMax, MultMin, 1'b0);
    drive_edge(CoordMin, CoordMin, CoordMax, CoordMax, MultMin, 1'b0);
    drive_edge(CoordMax, CoordMax, CoordMin, CoordMin, MultMin, 1'b1);
    drive_edge(CoordMin, CoordMax, CoordMax, CoordMin, '0, 1'b1);
    // sender holds off until every result is back
    drain();

    // query point at the coordinate extremes
    set_origin(CoordMax, CoordMin);
    drive_edge(CoordMin, CoordMin, CoordMin, CoordMax, 100, 1'b0);
    drive_edge(CoordMax, CoordMin, CoordMax, CoordMax, MultMax, 1'b1);
    drain();
    set_origin(CoordMin, CoordMax);
    drive_edge(CoordMax, CoordMax, CoordMax, CoordMin, 1, 1'b1);
    drain();
    set_origin(CoordMin, '0);
    drive_edge(CoordMax, CoordMin, CoordMax, CoordMax, MultMin, 1'b0);
    drive_edge(CoordMax, CoordMax, CoordMax, CoordMin, MultMax, 1'b1);
    drain();

    // random phases: slow receiver, then slow sender, then no idling at all
    set_origin(CoordW'($signed($urandom)), CoordW'($signed($urandom)));
    run_phase(28, 87);
    set_origin(CoordW'({$urandom, $urandom}), CoordW'({$urandom, $urandom}));
    run_phase(87, 28);
    set_origin(CoordW'($signed($urandom)), CoordW'($signed($urandom_range(1000))));
    run_phase(0, 0);

    // long casts running down and then up
    send_long_cast(1'b0);
    send_long_cast(1'b1);
    drain();

    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
